// ===== hw/rtl/fsmg_pkg.sv =====
// fsmg_pkg: shared constants, types and the gray conversion for the focus stack
// max gradient select block. No dependencies.
package fsmg_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 3 * CHAN_W;
   localparam int GRAY_W      = 8;
   localparam int GRAD_W      = GRAY_W + 1;
   localparam int ENERGY_W    = 17;
   localparam int COORD_W     = 9;
   localparam int SLICE_W     = 10;
   localparam int SIZE_CFG_W  = 10;
   localparam int SLICE_CFG_W = 11;
   localparam int SLICE_LIMIT = 1024;
   localparam int SIZE_RESET  = 512;
   localparam int SLICE_RESET = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_COUNT  = 2'd2;

   // one pixel to settle in the best-of-stack store
   typedef struct packed {
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COLOR_W-1:0]  color;
      logic [ENERGY_W-1:0] energy;
      logic                seed;
      logic                emit;
      logic                done;
   } settle_type;

   function automatic logic [GRAY_W-1:0] gray_of(input logic [COLOR_W-1:0] rgb);
      logic [13:0] sum;
      sum = 14'd11 * {6'b0, rgb[23:16]} + 14'd16 * {6'b0, rgb[15:8]}
          + 14'd5 * {6'b0, rgb[7:0]};
      return sum[12:5];
   endfunction

endpackage

// ===== hw/rtl/focus_stack_max_gradient_select_core.sv =====
// focus_stack_max_gradient_select_core: top level, configuration registers and
// the front / queue / back split. Depends on fsmg_pkg, fsmg_front, fsmg_queue, fsmg_back.
//
// Usage:
//   req_* carries RGB pixels of a focus stack in raster order, slice after slice.
//   rsp_* carries the fused pixels (column, row, colour) during the last slice;
//   rsp_frame_done marks the final pixel of the stack.
//   csr_* writes image_width (0), image_height (1) and slice_count (2); values
//   are clamped to their legal ranges and a write to any of them restarts at slice 0.
//   Write the registers only while the block is idle.
// Throughput: one pixel per cycle when the receiver does not stall. On the last
//   row of every slice each pixel settles two store entries (one when the image
//   has a single row), so that row takes a new pixel only after both are sent,
//   limited by the single update port of the best-of-stack store.
// Path: an input pixel passes s1, s2, s3, the queue, the back stage and result register.
// Reset: counters and handshake state clear; registers return to 512 x 512 with
//   one slice. Stores need no clearing, every entry is written before its value is used.
// Stall: a stalled receiver fills the result register, the back stage, the queue
//   and the front stages, after which req_ready drops; nothing is lost or repeated.
module focus_stack_max_gradient_select_core import fsmg_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CHAN_W-1:0]      req_in_red,
   input  logic [CHAN_W-1:0]      req_in_green,
   input  logic [CHAN_W-1:0]      req_in_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_W-1:0]     rsp_out_x,
   output logic [COORD_W-1:0]     rsp_out_y,
   output logic [CHAN_W-1:0]      rsp_out_red,
   output logic [CHAN_W-1:0]      rsp_out_green,
   output logic [CHAN_W-1:0]      rsp_out_blue,
   output logic                   rsp_frame_done,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);
   localparam int WEW = $clog2(MAX_WIDTH + 1);
   localparam int HEW = $clog2(MAX_HEIGHT + 1);
   localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int QW  = AW + $bits(settle_type);
   localparam int W_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
   localparam int H_RESET = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

   logic [WEW-1:0]         w_eff_ff, w_eff_in;
   logic [HEW-1:0]         h_eff_ff, h_eff_in;
   logic [SLICE_CFG_W-1:0] s_eff_ff, s_eff_in;
   logic [SIZE_CFG_W-1:0]  size_raw;
   logic [SLICE_CFG_W-1:0] slice_raw;
   logic                   cfg_restart;

   logic                   f_valid, f_ready, q_valid, q_ready;
   logic [AW-1:0]          f_addr, q_addr;
   settle_type             f_op, q_op;

   assign size_raw    = csr_write_data[SIZE_CFG_W-1:0];
   assign slice_raw   = csr_write_data[SLICE_CFG_W-1:0];
   assign cfg_restart = csr_write_enable && ((csr_index == CSR_IMAGE_WIDTH)
                        || (csr_index == CSR_IMAGE_HEIGHT) || (csr_index == CSR_SLICE_COUNT));

   always_comb begin
      w_eff_in = w_eff_ff;
      h_eff_in = h_eff_ff;
      s_eff_in = s_eff_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (size_raw == '0) w_eff_in = WEW'(1);
               else if (32'(size_raw) > MAX_WIDTH) w_eff_in = WEW'(MAX_WIDTH);
               else w_eff_in = WEW'(size_raw);
            end
            CSR_IMAGE_HEIGHT: begin
               if (size_raw == '0) h_eff_in = HEW'(1);
               else if (32'(size_raw) > MAX_HEIGHT) h_eff_in = HEW'(MAX_HEIGHT);
               else h_eff_in = HEW'(size_raw);
            end
            CSR_SLICE_COUNT: begin
               if (slice_raw == '0) s_eff_in = SLICE_CFG_W'(1);
               else if (32'(slice_raw) > SLICE_LIMIT) s_eff_in = SLICE_CFG_W'(SLICE_LIMIT);
               else s_eff_in = slice_raw;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff <= WEW'(W_RESET);
         h_eff_ff <= HEW'(H_RESET);
         s_eff_ff <= SLICE_CFG_W'(SLICE_RESET);
      end else begin
         w_eff_ff <= w_eff_in;
         h_eff_ff <= h_eff_in;
         s_eff_ff <= s_eff_in;
      end
   end

   fsmg_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg_restart  (cfg_restart),
      .w_eff        (w_eff_ff),
      .h_eff        (h_eff_ff),
      .s_eff        (s_eff_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .op_valid     (f_valid),
      .op_ready     (f_ready),
      .op_addr      (f_addr),
      .op           (f_op)
   );

   fsmg_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_addr, f_op}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   ({q_addr, q_op})
   );

   fsmg_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (q_valid),
      .op_ready       (q_ready),
      .op_addr        (q_addr),
      .op             (q_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_done (rsp_frame_done)
   );

   // the last fused pixel sits in the bottom right corner
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_out_x == COORD_W'(w_eff_ff - WEW'(1)))
      else $error("frame_done away from last column");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_out_y == COORD_W'(h_eff_ff - HEW'(1)))
      else $error("frame_done away from last row");

   // a settle request addresses the row its coordinates name
   assert property (@(posedge clock) disable iff (reset)
      f_valid |-> f_addr == AW'(f_op.y) * AW'(MAX_WIDTH) + AW'(f_op.x))
      else $error("settle address does not match coordinates");
endmodule

// ===== hw/rtl/fsmg_ram.sv =====
// fsmg_ram: generic single write port, single read port ram with registered read.
// Depends on nothing.
module fsmg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read-first: a same-cycle write is seen on the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/fsmg_queue.sv =====
// fsmg_queue: small register fifo between the front and back parts.
// Depends on nothing.
module fsmg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != (PW+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/fsmg_front.sv =====
// fsmg_front: pixel counters, row line buffers and the gradient energy pipeline.
// Emits one settle request per cycle unless stalled; uses fsmg_pkg and fsmg_ram.
module fsmg_front import fsmg_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      cfg_restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]            w_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]           h_eff,
   input  logic [SLICE_CFG_W-1:0]                    s_eff,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [CHAN_W-1:0]                         req_in_red,
   input  logic [CHAN_W-1:0]                         req_in_green,
   input  logic [CHAN_W-1:0]                         req_in_blue,
   output logic                                      op_valid,
   input  logic                                      op_ready,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   op_addr,
   output settle_type                                op
);
   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int WEW = $clog2(MAX_WIDTH + 1);
   localparam int HEW = $clog2(MAX_HEIGHT + 1);
   localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

   typedef struct packed {
      logic [XW-1:0]      x;
      logic [YW-1:0]      y;
      logic [COLOR_W-1:0] cur;
      logic [COLOR_W-1:0] mid;
      logic               has_center;
      logic               has_border;
      logic               col_last;
      logic               seed;
      logic               emit;
   } item_type;

   // counters and classification
   logic [XW-1:0]      col_ff, col_in;
   logic [YW-1:0]      row_ff, row_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic [WEW-1:0]     col_next;
   logic               col_wrap, row_last, slice_wrap, accept, interior;
   logic [XW-1:0]      next_col;
   logic [COLOR_W-1:0] cur, mid_sel, cmid_rd;
   logic [GRAY_W-1:0]  above_rd;
   logic [COLOR_W-1:0] held_left_ff, prev_cur_ff;

   // stages
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   item_type                 s1_ff, s2_ff, s3_ff;
   logic [COLOR_W-1:0]       s1_left_ff;
   logic                     s1_interior_ff;
   logic signed [GRAD_W-1:0] gx, gy, s2_gx_ff, s2_gy_ff;
   logic signed [2*GRAD_W-1:0] sq_x, sq_y;
   logic [ENERGY_W-1:0]      s3_energy_ff;
   logic                     s1_ready, s2_ready, s3_ready, s3_adv;
   logic                     phase_ff, phase_in, sel_center, has_op;
   logic [YW-1:0]            y_sel;

   assign cur      = {req_in_red, req_in_green, req_in_blue};
   assign accept   = req_valid && req_ready;
   assign col_next = WEW'(col_ff) + WEW'(1);
   assign col_wrap = col_next >= w_eff;
   assign next_col = col_wrap ? '0 : XW'(col_next);
   assign row_last = (HEW'(row_ff) + HEW'(1)) == h_eff;
   assign slice_wrap = (SLICE_CFG_W'(slice_ff) + SLICE_CFG_W'(1)) >= s_eff;
   // one-pixel rows: the previous row's colour is the previous item itself
   assign mid_sel  = (w_eff == WEW'(1)) ? prev_cur_ff : cmid_rd;
   assign interior = (col_ff != '0) && !col_wrap && (row_ff > YW'(1));

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      slice_in = slice_ff;
      if (cfg_restart) begin
         col_in   = '0;
         row_in   = '0;
         slice_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_last) begin
               row_in   = '0;
               slice_in = slice_wrap ? '0 : slice_ff + SLICE_W'(1);
            end else begin
               row_in = row_ff + YW'(1);
            end
         end else begin
            col_in = XW'(col_next);
         end
      end
   end

   // previous row colours, read one column ahead
   fsmg_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH)) u_color_row (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (cur),
      .rd_en   (accept),
      .rd_addr (next_col),
      .rd_data (cmid_rd)
   );

   // gray of the row two above
   fsmg_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_gray_row (
      .clock   (clock),
      .wr_en   (accept && (row_ff != '0)),
      .wr_addr (col_ff),
      .wr_data (gray_of(mid_sel)),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above_rd)
   );

   assign s3_ready  = !s3_valid_ff || s3_adv;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // s1 sees the ram reads of the item it holds
   always_comb begin
      gx = $signed({1'b0, gray_of(cmid_rd)}) - $signed({1'b0, gray_of(s1_left_ff)});
      gy = $signed({1'b0, gray_of(s1_ff.cur)}) - $signed({1'b0, above_rd});
      if (!s1_interior_ff) begin
         gx = '0;
         gy = '0;
      end
   end

   assign sq_x = s2_gx_ff * s2_gx_ff;
   assign sq_y = s2_gy_ff * s2_gy_ff;

   // emission: centre pixel first, then the bottom border pixel
   assign sel_center = s3_ff.has_center && !phase_ff;
   assign has_op     = sel_center || s3_ff.has_border;
   assign s3_adv     = s3_valid_ff && (!has_op || op_ready)
                       && !(sel_center && s3_ff.has_border);
   assign op_valid   = s3_valid_ff && has_op;
   assign y_sel      = sel_center ? s3_ff.y - YW'(1) : s3_ff.y;
   assign op_addr    = AW'(y_sel) * AW'(MAX_WIDTH) + AW'(s3_ff.x);

   always_comb begin
      op.x      = COORD_W'(s3_ff.x);
      op.y      = COORD_W'(y_sel);
      op.color  = sel_center ? s3_ff.mid : s3_ff.cur;
      op.energy = sel_center ? s3_energy_ff : '0;
      op.seed   = s3_ff.seed;
      op.emit   = s3_ff.emit;
      op.done   = !sel_center && s3_ff.col_last;
   end

   always_comb begin
      phase_in = phase_ff;
      if (s3_adv) begin
         phase_in = 1'b0;
      end else if (s3_valid_ff && op_ready && sel_center && s3_ff.has_border) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         slice_ff     <= '0;
         held_left_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         slice_ff <= slice_in;
         phase_ff <= phase_in;
         if (accept) begin
            held_left_ff <= mid_sel;
         end
         if (s1_ready) begin
            s1_valid_ff <= accept;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
      if (accept) begin
         prev_cur_ff       <= cur;
         s1_ff.x           <= col_ff;
         s1_ff.y           <= row_ff;
         s1_ff.cur         <= cur;
         s1_ff.mid         <= mid_sel;
         s1_ff.has_center  <= row_ff != '0;
         s1_ff.has_border  <= row_last;
         s1_ff.col_last    <= col_wrap;
         s1_ff.seed        <= slice_ff == '0;
         s1_ff.emit        <= (SLICE_CFG_W'(slice_ff) + SLICE_CFG_W'(1)) == s_eff;
         s1_left_ff        <= held_left_ff;
         s1_interior_ff    <= interior;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff    <= s1_ff;
         s2_gx_ff <= gx;
         s2_gy_ff <= gy;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff        <= s2_ff;
         s3_energy_ff <= ENERGY_W'(sq_x) + ENERGY_W'(sq_y);
      end
   end
endmodule

// ===== hw/rtl/fsmg_back.sv =====
// fsmg_back: best energy and colour store, compare and update, result register.
// Depends on fsmg_pkg and fsmg_ram.
module fsmg_back import fsmg_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    op_valid,
   output logic                                    op_ready,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] op_addr,
   input  settle_type                              op,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [COORD_W-1:0]                      rsp_out_x,
   output logic [COORD_W-1:0]                      rsp_out_y,
   output logic [CHAN_W-1:0]                       rsp_out_red,
   output logic [CHAN_W-1:0]                       rsp_out_green,
   output logic [CHAN_W-1:0]                       rsp_out_blue,
   output logic                                    rsp_frame_done
);
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic                b_valid_ff;
   logic [AW-1:0]       b_addr_ff;
   settle_type          b_op_ff;
   logic                fwd_valid_ff;
   logic [AW-1:0]       fwd_addr_ff;
   logic [ENERGY_W-1:0] fwd_energy_ff, energy_rd, stored_energy;
   logic [COLOR_W-1:0]  fwd_color_ff, color_rd, stored_color, final_color;
   logic                hit, do_write, out_free, b_fire, pop;

   logic                rsp_valid_ff;
   logic [COORD_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [COLOR_W-1:0]  rsp_color_ff;
   logic                rsp_done_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_fire   = b_valid_ff && (!b_op_ff.emit || out_free);
   assign op_ready = !b_valid_ff || b_fire;
   assign pop      = op_valid && op_ready;

   // the entry written in the cycle of this read is not in the ram data yet
   assign hit           = fwd_valid_ff && (fwd_addr_ff == b_addr_ff);
   assign stored_energy = hit ? fwd_energy_ff : energy_rd;
   assign stored_color  = hit ? fwd_color_ff : color_rd;
   // ties keep the earlier slice
   assign do_write      = b_op_ff.seed || (b_op_ff.energy > stored_energy);
   assign final_color   = do_write ? b_op_ff.color : stored_color;

   fsmg_ram #(.WIDTH(ENERGY_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_best_energy (
      .clock   (clock),
      .wr_en   (b_fire && do_write),
      .wr_addr (b_addr_ff),
      .wr_data (b_op_ff.energy),
      .rd_en   (pop),
      .rd_addr (op_addr),
      .rd_data (energy_rd)
   );

   fsmg_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_best_color (
      .clock   (clock),
      .wr_en   (b_fire && do_write),
      .wr_addr (b_addr_ff),
      .wr_data (b_op_ff.color),
      .rd_en   (pop),
      .rd_addr (op_addr),
      .rd_data (color_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op_ready) begin
            b_valid_ff <= op_valid;
         end
         if (b_fire && do_write) begin
            fwd_valid_ff <= 1'b1;
         end
         if (b_fire && b_op_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         b_addr_ff <= op_addr;
         b_op_ff   <= op;
      end
      if (b_fire && do_write) begin
         fwd_addr_ff   <= b_addr_ff;
         fwd_energy_ff <= b_op_ff.energy;
         fwd_color_ff  <= b_op_ff.color;
      end
      if (b_fire && b_op_ff.emit) begin
         rsp_x_ff     <= b_op_ff.x;
         rsp_y_ff     <= b_op_ff.y;
         rsp_color_ff <= final_color;
         rsp_done_ff  <= b_op_ff.done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_out_red    = rsp_color_ff[23:16];
   assign rsp_out_green  = rsp_color_ff[15:8];
   assign rsp_out_blue   = rsp_color_ff[7:0];
   assign rsp_frame_done = rsp_done_ff;
endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for focus_stack_max_gradient_select_core.
// Drives pixel stacks under random idling and checks every fused pixel against
// an internal predictor. Depends on fsmg_pkg and the core RTL.
module tb_top;
   import fsmg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_W     = 512;
   localparam int STORE_DEPTH = 512 * 512;
   localparam int DRAIN_WAIT  = 16;
   localparam int LONG_HOLD   = 300;
   localparam int RANDOM_ITEMS = 600;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               done;
   } fused_type;

   typedef struct {
      int unsigned        slices;
      logic [COLOR_W-1:0] rgb;
      bit                 typed;
      fused_type          want;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CHAN_W-1:0]      req_in_red;
   logic [CHAN_W-1:0]      req_in_green;
   logic [CHAN_W-1:0]      req_in_blue;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [COORD_W-1:0]     rsp_out_x;
   logic [COORD_W-1:0]     rsp_out_y;
   logic [CHAN_W-1:0]      rsp_out_red;
   logic [CHAN_W-1:0]      rsp_out_green;
   logic [CHAN_W-1:0]      rsp_out_blue;
   logic                   rsp_frame_done;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   focus_stack_max_gradient_select_core u_dut (.*);

   // predictor state
   int unsigned        raw_width, raw_height, raw_slices;
   logic [GRAY_W-1:0]  gray_above [STORE_W];
   logic [COLOR_W-1:0] middle_row [STORE_W];
   logic [COLOR_W-1:0] left_color;
   logic [ENERGY_W-1:0] best_energy [STORE_DEPTH];
   logic [COLOR_W-1:0] best_color [STORE_DEPTH];
   int unsigned        col_pos, row_pos, slice_pos;

   fused_type fused_q[$];
   fused_type fresh_q[$];
   int     errors;
   bit     calm;
   bit     hold_request;

   function automatic int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int luma(logic [COLOR_W-1:0] c);
      return (11 * int'(c[23:16]) + 16 * int'(c[15:8]) + 5 * int'(c[7:0])) / 32;
   endfunction

   task automatic settle_pixel(int unsigned cx, int unsigned cy, int unsigned e,
                               logic [COLOR_W-1:0] c);
      int unsigned idx;
      fused_type f;
      idx = cy * STORE_W + cx;
      if (slice_pos == 0 || e > best_energy[idx]) begin
         best_energy[idx] = e[ENERGY_W-1:0];
         best_color[idx]  = c;
      end
      if (slice_pos + 1 == clamp(raw_slices, SLICE_LIMIT)) begin
         f.x     = cx[COORD_W-1:0];
         f.y     = cy[COORD_W-1:0];
         f.color = best_color[idx];
         f.done  = (cx + 1 == clamp(raw_width, STORE_W)) && (cy + 1 == clamp(raw_height, 512));
         fresh_q = {fresh_q, f};
      end
   endtask

   task automatic predict_fusion(logic [COLOR_W-1:0] cur);
      int unsigned w, h, x, y, e;
      int gx, gy;
      logic [COLOR_W-1:0] mid;
      w = clamp(raw_width, STORE_W);
      h = clamp(raw_height, 512);
      x = (col_pos >= w) ? 0 : col_pos;
      y = (row_pos >= h) ? 0 : row_pos;
      mid = middle_row[x];
      fresh_q.delete();
      if (y >= 1) begin
         e = 0;
         if (x != 0 && x + 1 < w && y - 1 != 0 && y < h) begin
            gx = luma(middle_row[x + 1]) - luma(left_color);
            gy = luma(cur) - int'(gray_above[x]);
            e = gx * gx + gy * gy;
         end
         settle_pixel(x, y - 1, e, mid);
         gray_above[x] = GRAY_W'(luma(mid));
      end
      left_color = mid;
      middle_row[x] = cur;
      if (y + 1 == h) settle_pixel(x, y, 0, cur);
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) begin
            y = 0;
            slice_pos++;
            if (slice_pos >= clamp(raw_slices, SLICE_LIMIT)) slice_pos = 0;
         end
      end
      col_pos = x;
      row_pos = y;
   endtask

   task automatic report(string what, int got, int want);
      $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall_left;
      fused_type f;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (fused_q.size() == 0) begin
               report("unexpected transfer x", rsp_out_x, 0);
            end else begin
               f = fused_q.pop_front();
               if (rsp_out_x !== f.x) report("out_x", rsp_out_x, f.x);
               if (rsp_out_y !== f.y) report("out_y", rsp_out_y, f.y);
               if (rsp_out_red !== f.color[23:16]) report("out_red", rsp_out_red, f.color[23:16]);
               if (rsp_out_green !== f.color[15:8])
                  report("out_green", rsp_out_green, f.color[15:8]);
               if (rsp_out_blue !== f.color[7:0]) report("out_blue", rsp_out_blue, f.color[7:0]);
               if (rsp_frame_done !== f.done) report("frame_done", rsp_frame_done, f.done);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_pixel(logic [COLOR_W-1:0] rgb);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_red   <= rgb[23:16];
      req_in_green <= rgb[15:8];
      req_in_blue  <= rgb[7:0];
      do @(posedge clock); while (!req_ready);
      predict_fusion(rgb);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (fused_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      req_valid        <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  raw_width  = value & 'h3ff;
         CSR_IMAGE_HEIGHT: raw_height = value & 'h3ff;
         CSR_SLICE_COUNT:  raw_slices = value & 'h7ff;
         default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
      slice_pos = 0;
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned s);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_SLICE_COUNT, s);
   endtask

   function automatic logic [COLOR_W-1:0] pick_color();
      logic [COLOR_W-1:0] c;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 3))
            0: c[i*8 +: 8] = 8'h00;
            1: c[i*8 +: 8] = 8'hff;
            default: c[i*8 +: 8] = $urandom_range(0, 255);
         endcase
      end
      return c;
   endfunction

   task automatic send_many(int unsigned count);
      repeat (count) begin
         send_pixel(pick_color());
         fused_q = {fused_q, fresh_q};
      end
   endtask

   // single-pixel frames: with one slice every result reads straight off the input,
   // and with two slices the energy tie keeps the first slice
   stim_row_type directed[] = '{
      '{1, 24'h000000, 1, '{0, 0, 24'h000000, 1}},
      '{1, 24'hffffff, 1, '{0, 0, 24'hffffff, 1}},
      '{1, 24'hff0000, 1, '{0, 0, 24'hff0000, 1}},
      '{1, 24'h00ff00, 1, '{0, 0, 24'h00ff00, 1}},
      '{1, 24'h0000ff, 1, '{0, 0, 24'h0000ff, 1}},
      '{1, 24'h5a3c96, 0, '{0, 0, 0, 0}},
      '{1, 24'haa55aa, 0, '{0, 0, 0, 0}},
      '{2, 24'h123456, 0, '{0, 0, 0, 0}},
      '{2, 24'hffffff, 1, '{0, 0, 24'h123456, 1}},
      '{2, 24'h000000, 0, '{0, 0, 0, 0}},
      '{2, 24'hffffff, 1, '{0, 0, 24'h000000, 1}},
      '{2, 24'h808080, 0, '{0, 0, 0, 0}},
      '{2, 24'h7f7f7f, 0, '{0, 0, 0, 0}}
   };

   initial begin
      int unsigned sent, w, h, s, total;
      int unsigned cur_slices;
      errors = 0;
      calm = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_red = '0;
      req_in_green = '0;
      req_in_blue = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      raw_width = SIZE_RESET;
      raw_height = SIZE_RESET;
      raw_slices = SLICE_RESET;
      left_color = '0;
      col_pos = 0;
      row_pos = 0;
      slice_pos = 0;
      for (int i = 0; i < STORE_W; i++) begin
         gray_above[i] = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         best_energy[i] = '0;
         best_color[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero sizes clamp up to one pixel
      cur_slices = 0;
      write_reg(CSR_UNUSED, 'h7ff);
      foreach (directed[i]) begin
         if (directed[i].slices != cur_slices) begin
            cur_slices = directed[i].slices;
            set_geometry(0, 0, cur_slices);
         end
         send_pixel(directed[i].rgb);
         if (directed[i].typed) fused_q = {fused_q, directed[i].want};
         else fused_q = {fused_q, fresh_q};
      end

      // extremes: widest row with a long receiver hold-off, tallest column,
      // slice count clamped to its top
      set_geometry(1023, 1, 1);
      hold_request = 1'b1;
      send_many(512);
      set_geometry(1, 1023, 1);
      send_many(512);
      set_geometry(3, 3, 2047);
      send_many(9 * 1024 / 64);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 9);
         s = $urandom_range(1, 3);
         if ($urandom_range(0, 9) == 0) w = w + 600;
         total = clamp(w, STORE_W) * h * s * $urandom_range(1, 2);
         // broken stack: cut short, restarted by the next register write
         if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
         if (total > RANDOM_ITEMS - sent) total = RANDOM_ITEMS - sent;
         if (sent + total >= RANDOM_ITEMS - 200) calm = 1'b1;
         set_geometry(w, h, s);
         send_many(total);
         sent += total;
      end
      wait_idle();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== focus_stack_max_gradient_select_core.f =====
hw/rtl/fsmg_pkg.sv
hw/rtl/fsmg_ram.sv
hw/rtl/fsmg_queue.sv
hw/rtl/fsmg_front.sv
hw/rtl/fsmg_back.sv
hw/rtl/focus_stack_max_gradient_select_core.sv
dv/tb_top.sv
